>>> hw/rtl/jdv_pkg.sv
// Shared types, constants and register codes of the joystick deadzone and velocity unit.
package jdv_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int GAIN_W        = 15;
  localparam int VEL_W         = 8;
  localparam int VEL_FRAC_BITS = 7;
  localparam int AVG_COUNT_DEF = 16;
  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int PROD_W        = SAMPLE_BITS + GAIN_W;

  localparam logic [VEL_W-2:0] VEL_MAX = 7'd127;

  localparam logic [1:0] REG_DEADZONE = 2'd0;
  localparam logic [1:0] REG_GAIN     = 2'd1;
  localparam logic [1:0] REG_INV_X    = 2'd2;
  localparam logic [1:0] REG_INV_Y    = 2'd3;

  localparam logic AXIS_X   = 1'b0;
  localparam logic AXIS_Y   = 1'b1;
  localparam logic ACT_CAL  = 1'b0;
  localparam logic ACT_MEAS = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
  } in_item_t;

  typedef struct packed {
    logic                    axis;
    logic signed [VEL_W-1:0] velocity;
    logic                    sync_last;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] deadzone_width;
    logic [GAIN_W-1:0]      speed_gain;
    logic                   invert_x_axis;
    logic                   invert_y_axis;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic cal_acc;
    logic cal_clear;
    logic axis;
    logic div_start;
    logic ctr_load;
    logic ax_prep;
    logic ax_mul;
    logic ax_fin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic action;
    logic cal_full;
    logic div_busy;
    logic div_done;
    logic ax_skip;
    logic vel_nz_x;
    logic vel_nz_y;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/joystick_deadzone_velocity_unit.sv
// Top level of the joystick deadzone and velocity unit.
// Takes one X/Y sample pair per word. A calibration word adds to the per-axis sums; the
// one that closes a batch of AVG_COUNT words also loads both centers from a constant
// reciprocal multiply of the sums. A measurement word is accepted, then each axis goes
// through deflection, multiply and range check, and through the divider when the quotient
// is found one bit a cycle; the events are then handed out, waiting while the output
// register is held. Nonzero X, then nonzero Y, events leave through a registered output;
// sync_last marks the last of a pair. Write the configuration only while the unit is
// idle.
module joystick_deadzone_velocity_unit #(
  parameter int AVG_COUNT = jdv_pkg::AVG_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  jdv_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output jdv_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jdv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jdv_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jdv_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import jdv_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  jdv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jdv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  jdv_datapath #(
    .AVG_COUNT (AVG_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_data   (in_data),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |-> (!out_valid || out_ready))
    else $error("output register overwritten while held");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.div_start |-> !dp_stat.div_busy)
    else $error("divider started while busy");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_y_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.sync_last) |=> (out_valid && out_data.axis))
    else $error("Y event did not follow a non-final X event");

endmodule

>>> hw/rtl/jdv_regs.sv
// Configuration register bank behind the APB-style port.
module jdv_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jdv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jdv_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jdv_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output jdv_pkg::cfg_t                  cfg_o
);
  import jdv_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DEADZONE: cfg_nxt.deadzone_width = pwdata[SAMPLE_BITS-1:0];
        REG_GAIN:     cfg_nxt.speed_gain     = pwdata[GAIN_W-1:0];
        REG_INV_X:    cfg_nxt.invert_x_axis  = pwdata[0];
        REG_INV_Y:    cfg_nxt.invert_y_axis  = pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone_width <= '0;
      cfg_r.speed_gain     <= GAIN_W'(127);
      cfg_r.invert_x_axis  <= 1'b0;
      cfg_r.invert_y_axis  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEADZONE: prdata = CFG_DATA_W'(cfg_r.deadzone_width);
      REG_GAIN:     prdata = CFG_DATA_W'(cfg_r.speed_gain);
      REG_INV_X:    prdata = CFG_DATA_W'(cfg_r.invert_x_axis);
      REG_INV_Y:    prdata = CFG_DATA_W'(cfg_r.invert_y_axis);
      default:      prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/jdv_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module jdv_divider #(
  parameter int DVD_W = jdv_pkg::PROD_W,
  parameter int DVS_W = jdv_pkg::SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic [DVD_W-1:0]                   dividend_i,
  input  logic [DVS_W-1:0]                   divisor_i,
  output logic [jdv_pkg::VEL_FRAC_BITS-1:0]  quot_o,
  output logic                               busy_o,
  output logic                               done_o
);
  import jdv_pkg::*;

  localparam int Q_W   = VEL_FRAC_BITS;
  localparam int DSR_W = DVS_W + Q_W - 1;
  localparam int CMP_W = (DVD_W > DSR_W) ? DVD_W : DSR_W;
  localparam int CNT_W = $clog2(Q_W);

  logic [DVD_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CMP_W-1:0] rem_ext, dsr_ext;
  logic             ge;

  assign rem_ext = CMP_W'(rem_r);
  assign dsr_ext = CMP_W'(dsr_r);
  assign ge      = rem_ext >= dsr_ext;

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      // align the divisor with the top quotient bit
      rem_nxt  = dividend_i;
      dsr_nxt  = DSR_W'(divisor_i) << (Q_W - 1);
      cnt_nxt  = CNT_W'(Q_W - 1);
      q_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = DVD_W'(rem_ext - dsr_ext);
      end
      q_nxt   = {q_r[Q_W-2:0], ge};
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quot_o = q_r;
  assign busy_o = busy_r;
  assign done_o = done_r;

endmodule

>>> hw/rtl/jdv_datapath.sv
// Datapath: calibration sums, centers, per-axis scaling and the output register.
module jdv_datapath #(
  parameter int AVG_COUNT = jdv_pkg::AVG_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  jdv_pkg::cfg_t       cfg_i,
  input  jdv_pkg::in_item_t   in_data,
  input  jdv_pkg::dp_cmd_t    cmd_i,
  output jdv_pkg::dp_stat_t   stat_o,
  output logic                out_valid,
  input  logic                out_ready,
  output jdv_pkg::out_item_t  out_data
);
  import jdv_pkg::*;

  localparam int CNT_W   = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
  localparam int AVG_L   = $clog2(AVG_COUNT);
  localparam int SUM_W   = SAMPLE_BITS + AVG_L;
  // average as a multiply by the rounded-up reciprocal, exact over the whole sum range
  localparam int AVG_S   = SUM_W + AVG_L;
  localparam int AVG_M_W = SUM_W + 1;
  localparam int AVG_P_W = SUM_W + AVG_M_W;
  localparam longint AVG_M = ((longint'(1) << AVG_S) + longint'(AVG_COUNT) - longint'(1))
                             / longint'(AVG_COUNT);
  localparam int DW      = SAMPLE_BITS + 2;

  in_item_t               item_r;
  logic [SUM_W-1:0]       sum_x_r, sum_y_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SAMPLE_BITS-1:0] ctr_x_r, ctr_y_r;
  logic [SAMPLE_BITS-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic                   zero_r, zero_nxt;
  logic                   rnp_r, rnp_nxt;
  logic [SAMPLE_BITS-1:0] rdiv_r, rdiv_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [VEL_W-1:0] vel_x_r, vel_y_r, vel_nxt;
  logic                   nz_x_r, nz_y_r, nz_nxt;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [SAMPLE_BITS-1:0] smp, ctr;
  logic signed [DW-1:0]   d, dzs, m, r;
  logic                   in_band;
  logic                   sat;
  logic [VEL_W-2:0]       vmag;
  logic                   cal_full;
  logic [AVG_P_W-1:0]     avg_x_prod, avg_y_prod;
  logic [SAMPLE_BITS-1:0] avg_x, avg_y;
  logic [VEL_FRAC_BITS-1:0] quot;
  logic                   div_busy, div_done;
  logic                   out_free;

  // deflection, deadzone removal and the scaling range for the selected axis
  always_comb begin
    smp      = cmd_i.axis ? item_r.y_sample : item_r.x_sample;
    ctr      = cmd_i.axis ? ctr_y_r : ctr_x_r;
    d        = signed'({2'b00, smp}) - signed'({2'b00, ctr});
    dzs      = signed'({2'b00, cfg_i.deadzone_width});
    in_band  = (d > -dzs) && (d < dzs);
    m        = (d > 0) ? (d - dzs) : (d + dzs);
    mag_nxt  = m[DW-1] ? SAMPLE_BITS'(-m) : SAMPLE_BITS'(m);
    zero_nxt = in_band || (m == '0);
    neg_nxt  = m[DW-1] ^ (cmd_i.axis ? cfg_i.invert_y_axis : cfg_i.invert_x_axis);
    r        = signed'({2'b00, ctr}) - dzs;
    rnp_nxt  = r[DW-1] || (r == '0);
    rdiv_nxt = r[SAMPLE_BITS-1:0];
  end

  assign prod_nxt = {{GAIN_W{1'b0}}, mag_r} * {{SAMPLE_BITS{1'b0}}, cfg_i.speed_gain};

  // quotient would not fit in the velocity range
  assign sat = prod_r >= {{(PROD_W-SAMPLE_BITS-VEL_FRAC_BITS){1'b0}}, rdiv_r,
                          {VEL_FRAC_BITS{1'b0}}};

  always_comb begin
    if (zero_r) begin
      vmag = '0;
    end else if (rnp_r || sat) begin
      vmag = VEL_MAX;
    end else begin
      vmag = quot;
    end
    vel_nxt = neg_r ? -signed'({1'b0, vmag}) : signed'({1'b0, vmag});
    nz_nxt  = vmag != '0;
  end

  assign cal_full   = cnt_r == CNT_W'(AVG_COUNT - 1);
  assign avg_x_prod = AVG_P_W'(sum_x_r) * AVG_P_W'(AVG_M);
  assign avg_y_prod = AVG_P_W'(sum_y_r) * AVG_P_W'(AVG_M);
  assign avg_x      = avg_x_prod[AVG_S +: SAMPLE_BITS];
  assign avg_y      = avg_y_prod[AVG_S +: SAMPLE_BITS];

  jdv_divider #(
    .DVD_W (PROD_W),
    .DVS_W (SAMPLE_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_r),
    .divisor_i  (rdiv_r),
    .quot_o     (quot),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  // calibration state and centers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
      ctr_x_r <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
      ctr_y_r <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    end else begin
      if (cmd_i.cal_acc) begin
        sum_x_r <= sum_x_r + SUM_W'(item_r.x_sample);
        sum_y_r <= sum_y_r + SUM_W'(item_r.y_sample);
        cnt_r   <= cal_full ? '0 : cnt_r + CNT_W'(1);
      end else if (cmd_i.cal_clear) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
      end
      if (cmd_i.ctr_load) begin
        ctr_x_r <= avg_x;
        ctr_y_r <= avg_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      item_r <= in_data;
    end
    if (cmd_i.ax_prep) begin
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      zero_r <= zero_nxt;
      rnp_r  <= rnp_nxt;
      rdiv_r <= rdiv_nxt;
    end
    if (cmd_i.ax_mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd_i.ax_fin) begin
      if (cmd_i.axis == AXIS_Y) begin
        vel_y_r <= vel_nxt;
        nz_y_r  <= nz_nxt;
      end else begin
        vel_x_r <= vel_nxt;
        nz_x_r  <= nz_nxt;
      end
    end
    if (cmd_i.emit) begin
      out_r.axis      <= cmd_i.axis;
      out_r.velocity  <= (cmd_i.axis == AXIS_Y) ? vel_y_r : vel_x_r;
      out_r.sync_last <= (cmd_i.axis == AXIS_Y) || !nz_y_r;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stat_o.action   = in_data.action;
    stat_o.cal_full = cal_full;
    stat_o.div_busy = div_busy;
    stat_o.div_done = div_done;
    stat_o.ax_skip  = zero_r || rnp_r || sat;
    stat_o.vel_nz_x = nz_x_r;
    stat_o.vel_nz_y = nz_y_r;
    stat_o.out_free = out_free;
  end

endmodule

>>> hw/rtl/jdv_ctrl.sv
// Controller state machine: sequences calibration, averaging, per-axis scaling and output.
module jdv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jdv_pkg::dp_stat_t  stat_i,
  output jdv_pkg::dp_cmd_t   cmd_o
);
  import jdv_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CAL      = 9'b000000010,
    S_AVG      = 9'b000000100,
    S_AX_PREP  = 9'b000001000,
    S_AX_MUL   = 9'b000010000,
    S_AX_CHK   = 9'b000100000,
    S_AX_WAIT  = 9'b001000000,
    S_EMIT_X   = 9'b010000000,
    S_EMIT_Y   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd_o     = '0;
    cmd_o.axis = axis_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.latch = 1'b1;
          axis_nxt    = AXIS_X;
          state_nxt   = (stat_i.action == ACT_CAL) ? S_CAL : S_AX_PREP;
        end
      end
      S_CAL: begin
        cmd_o.cal_acc = 1'b1;
        state_nxt     = stat_i.cal_full ? S_AVG : S_IDLE;
      end
      S_AVG: begin
        // load both centers from the closed sums and restart the sums
        cmd_o.ctr_load  = 1'b1;
        cmd_o.cal_clear = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_AX_PREP: begin
        cmd_o.ax_prep = 1'b1;
        state_nxt     = S_AX_MUL;
      end
      S_AX_MUL: begin
        cmd_o.ax_mul = 1'b1;
        state_nxt    = S_AX_CHK;
      end
      S_AX_CHK: begin
        if (stat_i.ax_skip) begin
          cmd_o.ax_fin = 1'b1;
          axis_nxt     = AXIS_Y;
          state_nxt    = (axis_r == AXIS_Y) ? S_EMIT_X : S_AX_PREP;
        end else begin
          cmd_o.div_start = 1'b1;
          state_nxt       = S_AX_WAIT;
        end
      end
      S_AX_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.ax_fin = 1'b1;
          axis_nxt     = AXIS_Y;
          state_nxt    = (axis_r == AXIS_Y) ? S_EMIT_X : S_AX_PREP;
        end
      end
      S_EMIT_X: begin
        cmd_o.axis = AXIS_X;
        if (!stat_i.vel_nz_x) begin
          state_nxt = S_EMIT_Y;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = S_EMIT_Y;
        end
      end
      S_EMIT_Y: begin
        cmd_o.axis = AXIS_Y;
        if (!stat_i.vel_nz_y) begin
          state_nxt = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the joystick deadzone and velocity unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jdv_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Register copies and calibration state of the predictor
  logic [SAMPLE_BITS-1:0] dz_setting;
  logic [GAIN_W-1:0]      gain_setting;
  logic                   inv_x_setting;
  logic                   inv_y_setting;
  logic [SAMPLE_BITS-1:0] pred_ctr_x;
  logic [SAMPLE_BITS-1:0] pred_ctr_y;
  logic [15:0]            cal_sum_x;
  logic [15:0]            cal_sum_y;
  int                     cal_taken;

  out_item_t pending_events[$];

  int  mismatch_count = 0;
  int  pairs_taken = 0;
  int  events_seen = 0;
  int  batches_closed = 0;
  int  reg_writes = 0;
  bit  tx_gap_en = 1'b1;
  bit  rx_stall_en = 1'b1;
  bit  hold_request = 1'b0;

  joystick_deadzone_velocity_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic signed [VEL_W-1:0] axis_speed(input logic [SAMPLE_BITS-1:0] sample,
                                                        input logic [SAMPLE_BITS-1:0] center,
                                                        input logic inv);
    longint c, d, dz, m, r, v, g;
    c = center;
    d = sample;
    d = d - c;
    dz = dz_setting;
    g = gain_setting;
    r = c - dz;
    if (d > -dz && d < dz) return '0;
    m = (d > 0) ? d - dz : d + dz;
    if (m == 0) begin
      v = 0;
    end else if (r <= 0) begin
      // no usable range: saturate toward the sign of the deflection
      v = (m > 0) ? 127 : -127;
    end else begin
      v = (m * g) / r;
      if (v > 127) v = 127;
      if (v < -127) v = -127;
    end
    if (inv) v = -v;
    return v[VEL_W-1:0];
  endfunction

  function automatic void predict_pair(input in_item_t w);
    logic signed [VEL_W-1:0] vx, vy;
    out_item_t ev;
    if (w.action == ACT_CAL) begin
      cal_sum_x = cal_sum_x + w.x_sample;
      cal_sum_y = cal_sum_y + w.y_sample;
      cal_taken++;
      if (cal_taken >= AVG_COUNT_DEF) begin
        pred_ctr_x = SAMPLE_BITS'(cal_sum_x / AVG_COUNT_DEF);
        pred_ctr_y = SAMPLE_BITS'(cal_sum_y / AVG_COUNT_DEF);
        cal_sum_x = '0;
        cal_sum_y = '0;
        cal_taken = 0;
        batches_closed++;
      end
    end else begin
      vx = axis_speed(w.x_sample, pred_ctr_x, inv_x_setting);
      vy = axis_speed(w.y_sample, pred_ctr_y, inv_y_setting);
      if (vx != 0) begin
        ev.axis = AXIS_X;
        ev.velocity = vx;
        ev.sync_last = (vy == 0);
        pending_events.push_back(ev);
      end
      if (vy != 0) begin
        ev.axis = AXIS_Y;
        ev.velocity = vy;
        ev.sync_last = 1'b1;
        pending_events.push_back(ev);
      end
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_expect(input logic [1:0] idx);
    case (idx)
      REG_DEADZONE: return CFG_DATA_W'(dz_setting);
      REG_GAIN:     return CFG_DATA_W'(gain_setting);
      REG_INV_X:    return CFG_DATA_W'(inv_x_setting);
      default:      return CFG_DATA_W'(inv_y_setting);
    endcase
  endfunction

  task automatic read_reg(input logic [1:0] idx);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_expect(idx))
      flag_mismatch($sformatf("register %0d read 0x%0h, want 0x%0h", idx, prdata,
                              reg_expect(idx)));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // bits above the register width are dropped
    case (idx)
      REG_DEADZONE: dz_setting = value[SAMPLE_BITS-1:0];
      REG_GAIN:     gain_setting = value[GAIN_W-1:0];
      REG_INV_X:    inv_x_setting = value[0];
      default:      inv_y_setting = value[0];
    endcase
    reg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_reg(idx);
  endtask

  // Offer one sample pair; return once the block has taken the word.
  task automatic offer_pair(input logic act, input logic [SAMPLE_BITS-1:0] xs,
                            input logic [SAMPLE_BITS-1:0] ys);
    int gap, k;
    in_item_t w;
    gap = 0;
    if (tx_gap_en) begin
      k = $urandom_range(0, 99);
      if (k >= 95) gap = $urandom_range(10, 40);
      else if (k >= 75) gap = $urandom_range(1, 3);
    end
    w.action = act;
    w.x_sample = xs;
    w.y_sample = ys;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pairs_taken++;
    predict_pair(w);
  endtask

  task automatic send_cal_batch(input logic [SAMPLE_BITS-1:0] x_level,
                                input logic [SAMPLE_BITS-1:0] y_level, input int jitter);
    do begin
      offer_pair(ACT_CAL, x_level ^ SAMPLE_BITS'($urandom_range(0, jitter)),
                 y_level ^ SAMPLE_BITS'($urandom_range(0, jitter)));
    end while (cal_taken != 0);
  endtask

  // Drop valid, wait for every event, then let a closing average finish.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] center);
    int v, k, dz;
    k = $urandom_range(0, 99);
    dz = dz_setting;
    if (k < 40) return SAMPLE_BITS'($urandom_range(0, 4095));
    if (k < 55) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    v = center;
    if (k < 85) v = v + int'($urandom_range(0, 2 * dz + 8)) - (dz + 4);
    else v = v + ($urandom_range(0, 1) ? dz : -dz) + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk) begin : check_events
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("event axis %0d velocity %0d with nothing pending",
                                out_data.axis, out_data.velocity));
      end else begin
        want = pending_events.pop_front();
        if (out_data.axis !== want.axis)
          flag_mismatch($sformatf("axis %0d, want %0d", out_data.axis, want.axis));
        if (out_data.velocity !== want.velocity)
          flag_mismatch($sformatf("velocity %0d, want %0d", out_data.velocity,
                                  want.velocity));
        if (out_data.sync_last !== want.sync_last)
          flag_mismatch($sformatf("sync_last %0d, want %0d", out_data.sync_last,
                                  want.sync_last));
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin : event_sink
    int k;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (rx_stall_en && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        k = $urandom_range(0, 99);
        repeat (k < 85 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_register_defaults();
    for (int i = 0; i < 4; i++) read_reg(i[1:0]);
  endtask

  task automatic test_reset_center();
    offer_pair(ACT_MEAS, 12'h000, 12'hFFF);
    offer_pair(ACT_MEAS, 12'hFFF, 12'h000);
    offer_pair(ACT_MEAS, 12'd2048, 12'd2048);
    offer_pair(ACT_MEAS, 12'd2049, 12'd2047);
  endtask

  task automatic test_deadzone_edges();
    settle_idle();
    write_reg(REG_DEADZONE, 32'd100);
    write_reg(REG_GAIN, 32'd32767);
    offer_pair(ACT_MEAS, 12'd2148, 12'd1948);
    offer_pair(ACT_MEAS, 12'd2147, 12'd1949);
    offer_pair(ACT_MEAS, 12'd2149, 12'd1947);
    settle_idle();
    write_reg(REG_INV_X, 32'd1);
    write_reg(REG_INV_Y, 32'hFFFF_FFFF);
    offer_pair(ACT_MEAS, 12'hFFF, 12'h000);
  endtask

  task automatic test_zero_gain();
    settle_idle();
    write_reg(REG_GAIN, 32'hFFFF_0000);
    write_reg(REG_INV_X, 32'd0);
    write_reg(REG_INV_Y, 32'd0);
    offer_pair(ACT_MEAS, 12'hFFF, 12'h000);
    offer_pair(ACT_MEAS, 12'h000, 12'hFFF);
  endtask

  task automatic test_calibration_range();
    settle_idle();
    send_cal_batch(12'h000, 12'hFFF, 15);
    settle_idle();
    // deadzone past the X center leaves no range on that axis
    write_reg(REG_DEADZONE, 32'(pred_ctr_x) + 32'd3);
    write_reg(REG_GAIN, 32'd100);
    offer_pair(ACT_MEAS, 12'hFFF, 12'h000);
    offer_pair(ACT_MEAS, pred_ctr_x, pred_ctr_y);
    settle_idle();
    write_reg(REG_INV_X, 32'd1);
    offer_pair(ACT_MEAS, 12'hFFF, 12'h000);
  endtask

  task automatic test_output_backpressure();
    settle_idle();
    tx_gap_en = 1'b0;
    hold_request = 1'b1;
    repeat (40) offer_pair(ACT_MEAS, SAMPLE_BITS'($urandom_range(3000, 4095)),
                           SAMPLE_BITS'($urandom_range(0, 1000)));
    tx_gap_en = 1'b1;
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    int k, start;
    logic [SAMPLE_BITS-1:0] lvl_x, lvl_y;
    for (int p = 0; p < phases; p++) begin
      settle_idle();
      tx_gap_en = (p % 4 != 3);
      rx_stall_en = (p % 4 != 3);
      k = $urandom_range(0, 99);
      write_reg(REG_DEADZONE, {20'($urandom()),
                               k < 20 ? 12'd0 : k < 35 ? 12'hFFF :
                               k < 70 ? SAMPLE_BITS'($urandom_range(0, 64)) :
                                        SAMPLE_BITS'($urandom_range(0, 4095))});
      k = $urandom_range(0, 99);
      write_reg(REG_GAIN, {17'($urandom()),
                           k < 15 ? 15'd0 : k < 30 ? 15'h7FFF : k < 50 ? 15'd127 :
                                    GAIN_W'($urandom_range(0, 32767))});
      write_reg(REG_INV_X, {31'($urandom()), 1'($urandom_range(0, 1))});
      write_reg(REG_INV_Y, {31'($urandom()), 1'($urandom_range(0, 1))});
      start = pairs_taken;
      while (pairs_taken - start < per_phase) begin
        k = $urandom_range(0, 99);
        if (k < 3) begin
          k = $urandom_range(0, 3);
          lvl_x = k == 0 ? 12'h000 : k == 1 ? 12'hFFF : SAMPLE_BITS'($urandom());
          k = $urandom_range(0, 3);
          lvl_y = k == 0 ? 12'h000 : k == 1 ? 12'hFFF : SAMPLE_BITS'($urandom());
          send_cal_batch(lvl_x, lvl_y, $urandom_range(0, 255));
        end else if (k < 8) begin
          offer_pair(ACT_CAL, SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()));
        end else begin
          offer_pair(ACT_MEAS, pick_sample(pred_ctr_x), pick_sample(pred_ctr_y));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    dz_setting = '0;
    gain_setting = GAIN_W'(127);
    inv_x_setting = 1'b0;
    inv_y_setting = 1'b0;
    pred_ctr_x = SAMPLE_BITS'(2048);
    pred_ctr_y = SAMPLE_BITS'(2048);
    cal_sum_x = '0;
    cal_sum_y = '0;
    cal_taken = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_reset_center();
    test_deadzone_edges();
    test_zero_gain();
    test_calibration_range();
    test_output_backpressure();
    test_random_traffic(12, 148);
    settle_idle();

    $display("Covered %0d sample pairs, %0d calibration averages, %0d register writes",
             pairs_taken, batches_closed, reg_writes);
    $display("Checked %0d movement events against prediction, %0d mismatches",
             events_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> joystick_deadzone_velocity_unit.f
hw/rtl/jdv_pkg.sv
hw/rtl/jdv_regs.sv
hw/rtl/jdv_divider.sv
hw/rtl/jdv_datapath.sv
hw/rtl/jdv_ctrl.sv
hw/rtl/joystick_deadzone_velocity_unit.sv
sim/testbench.sv
